// File: rtl/mtm_pkg.sv
// Shared types and constants for the magnitude threshold mask block.
// Used by mtm_front, mtm_fifo, mtm_back and magnitude_threshold_mask.
// No dependencies.
package mtm_pkg;

	// field and state widths
	localparam int MAG_W   = 16;
	localparam int PHASE_W = 16;
	localparam int THR_W   = 7;
	localparam int SUM_W   = 40;
	localparam int CNT_W   = 25;
	localparam int M100_W  = 23;	// mag * 100 fits in 16 + 7 bits
	localparam int PROD_W  = 48;	// (mag * 100) * count

	localparam logic [THR_W-1:0] THR_RESET  = 7'd20;
	localparam logic [CNT_W-1:0] VOXELS_MAX = 25'd16777216;
	localparam logic [6:0]       PCT_SCALE  = 7'd100;

	// decoupling queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// pass selector codes
	typedef enum logic [1:0] {
		FUNC_MAX  = 2'd0,
		FUNC_AVG  = 2'd1,
		FUNC_MASK = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	// one mask-pass voxel with its decision
	typedef struct packed {
		logic        [MAG_W-1:0]   mag_first;
		logic        [MAG_W-1:0]   mag_second;
		logic signed [PHASE_W-1:0] phase_first;
		logic signed [PHASE_W-1:0] phase_second;
		logic                      last;
		logic                      hide;
	} voxel_t;

	// queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

// File: rtl/mtm_front.sv
// Front end: accepts beats, keeps max/sum/count state, computes the mask decision.
// Two pipeline stages (snapshot, multiply) then a compare feeding the queue.
// Depends on mtm_pkg.
module mtm_front import mtm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [MAG_W-1:0]          mag_first,
	input  logic [MAG_W-1:0]          mag_second,
	input  logic signed [PHASE_W-1:0] phase_first,
	input  logic signed [PHASE_W-1:0] phase_second,
	input  logic                      last,
	input  logic                      cfg_we,
	input  logic [THR_W-1:0]          cfg_wdata,
	input  fifo_stat_t                q_stat,
	output logic                      push,
	output voxel_t                    push_data
);

	logic [THR_W-1:0] thr_q;
	logic [MAG_W-1:0] max_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;

	logic valid_s1, valid_s2;
	logic accept, load_s1, load_s2, s1_free, s2_free;
	logic bright;
	logic [SUM_W:0] sum_add;
	func_t fn;

	voxel_t            vox_s1, vox_s2;
	logic [M100_W-1:0] m100_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic [PROD_W-1:0] lhs_s2, rhs_s2;
	logic              en_s2;

	// pipeline flow control; the stall and push terms come from registers
	assign push    = valid_s2 && !q_stat.full;
	assign s2_free = !valid_s2 || push;
	assign load_s2 = valid_s1 && s2_free;
	assign s1_free = !valid_s1 || load_s2;
	assign in_stall = !s1_free;
	assign accept  = in_valid && s1_free;
	assign fn      = func_t'(func);
	assign load_s1 = accept && (fn == FUNC_MASK);

	// bright test and saturating sum
	assign bright  = {mag_second, 1'b0} > {1'b0, max_q};
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(mag_second);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// volume statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			unique case (fn)
				FUNC_MAX: begin
					if (mag_second > max_q) max_q <= mag_second;
				end
				FUNC_AVG: begin
					if (bright) begin
						sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
						if (cnt_q < VOXELS_MAX) cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				FUNC_MASK: begin
					// end of mask pass clears the volume state
					if (last) begin
						max_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
					end
				end
				FUNC_NONE: ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)      valid_s1 <= 1'b1;
			else if (load_s2) valid_s1 <= 1'b0;
			if (load_s2)      valid_s2 <= 1'b1;
			else if (push)    valid_s2 <= 1'b0;
		end
	end

	// stage 1: payload and state snapshot
	always_ff @(posedge clk) begin
		if (load_s1) begin
			vox_s1.mag_first    <= mag_first;
			vox_s1.mag_second   <= mag_second;
			vox_s1.phase_first  <= phase_first;
			vox_s1.phase_second <= phase_second;
			vox_s1.last         <= last;
			vox_s1.hide         <= 1'b0;
			m100_s1 <= M100_W'(mag_second) * M100_W'(PCT_SCALE);
			cnt_s1  <= cnt_q;
			sum_s1  <= sum_q;
		end
	end

	// stage 2: both sides of mag*100*count < thr*sum
	always_ff @(posedge clk) begin
		if (load_s2) begin
			vox_s2 <= vox_s1;
			lhs_s2 <= PROD_W'(m100_s1) * PROD_W'(cnt_s1);
			rhs_s2 <= PROD_W'(thr_q) * PROD_W'(sum_s1);
			en_s2  <= (thr_q != '0) && (cnt_s1 != '0);
		end
	end

	// compare and hand to the queue
	always_comb begin
		push_data      = vox_s2;
		push_data.hide = en_s2 && (lhs_s2 < rhs_s2);
	end

endmodule

// File: rtl/mtm_fifo.sv
// Short queue between the front end and the output stage.
// Register array with one write and one read pointer.
// Depends on mtm_pkg.
module mtm_fifo import mtm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  voxel_t     push_data,
	input  logic       pop,
	output voxel_t     head,
	output fifo_stat_t stat
);

	voxel_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + FIFO_AW'(1);
			if (pop)  rd_q <= rd_q + FIFO_AW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (FIFO_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (FIFO_AW+1)'(1);
				default: ;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// File: rtl/mtm_back.sv
// Output stage: pops decided voxels, applies zeroing, holds the output beat.
// Depends on mtm_pkg.
module mtm_back import mtm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  voxel_t                     head,
	input  fifo_stat_t                 q_stat,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [MAG_W-1:0]           out_mag_first,
	output logic [MAG_W-1:0]           out_mag_second,
	output logic signed [PHASE_W-1:0]  out_phase_first,
	output logic signed [PHASE_W-1:0]  out_phase_second,
	output logic                       masked,
	output logic                       out_last
);

	logic valid_q;

	// refill the output register when empty or being taken
	assign pop       = !q_stat.empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output beat, zeroed when hidden
	always_ff @(posedge clk) begin
		if (pop) begin
			out_mag_first    <= head.hide ? '0 : head.mag_first;
			out_mag_second   <= head.hide ? '0 : head.mag_second;
			out_phase_first  <= head.hide ? '0 : head.phase_first;
			out_phase_second <= head.hide ? '0 : head.phase_second;
			masked           <= head.hide;
			out_last         <= head.last;
		end
	end

endmodule

// File: rtl/magnitude_threshold_mask.sv
// Magnitude threshold mask, top level. Depends on mtm_pkg, mtm_front, mtm_fifo, mtm_back.
// Throughput: one beat per cycle on every pass while not stalled; a 4-entry queue decouples the output.
// Path: a mask-pass beat passes the snapshot and multiply stages, is compared into the queue
// and is then held in the output register; other passes give no beat.
// Reset (arst_n low, asynchronous): statistics cleared, threshold back to 20,
// queue and output emptied.
module magnitude_threshold_mask import mtm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [MAG_W-1:0]           mag_first,
	input  logic [MAG_W-1:0]           mag_second,
	input  logic signed [PHASE_W-1:0]  phase_first,
	input  logic signed [PHASE_W-1:0]  phase_second,
	input  logic                       last,
	input  logic                       cfg_we,
	input  logic [THR_W-1:0]           cfg_wdata,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [MAG_W-1:0]           out_mag_first,
	output logic [MAG_W-1:0]           out_mag_second,
	output logic signed [PHASE_W-1:0]  out_phase_first,
	output logic signed [PHASE_W-1:0]  out_phase_second,
	output logic                       masked,
	output logic                       out_last
);

	logic       push, pop;
	voxel_t     push_data, head;
	fifo_stat_t q_stat;

	mtm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.mag_first    (mag_first),
		.mag_second   (mag_second),
		.phase_first  (phase_first),
		.phase_second (phase_second),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	mtm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	mtm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.q_stat           (q_stat),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_mag_first    (out_mag_first),
		.out_mag_second   (out_mag_second),
		.out_phase_first  (out_phase_first),
		.out_phase_second (out_phase_second),
		.masked           (masked),
		.out_last         (out_last)
	);

endmodule

// File: bench/mtm_mask_checker.sv
`timescale 1ns / 1ps
// Checker for magnitude_threshold_mask: follows the volume statistics and the threshold,
// predicts every mask-pass beat and compares it with the output channel.
// Depends on mtm_pkg.
module mtm_mask_checker import mtm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [MAG_W-1:0]           mag_first,
	input  logic [MAG_W-1:0]           mag_second,
	input  logic signed [PHASE_W-1:0]  phase_first,
	input  logic signed [PHASE_W-1:0]  phase_second,
	input  logic                       last,
	input  logic                       cfg_we,
	input  logic [THR_W-1:0]           cfg_wdata,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [MAG_W-1:0]           out_mag_first,
	input  logic [MAG_W-1:0]           out_mag_second,
	input  logic signed [PHASE_W-1:0]  out_phase_first,
	input  logic signed [PHASE_W-1:0]  out_phase_second,
	input  logic                       masked,
	input  logic                       out_last,
	output int                         mismatch_count,
	output int                         pending
);

	// shadow statistics and threshold
	logic [MAG_W-1:0] peak_mag;
	logic [SUM_W-1:0] bright_sum;
	logic [CNT_W-1:0] bright_count;
	logic [THR_W-1:0] level_pct;
	logic [SUM_W:0]   sum_next;

	voxel_t expected_voxels[$];
	voxel_t want;
	voxel_t got;
	logic   hide_it;
	int     bad_beats;

	// exact compare, no division: mag*100*count < pct*sum
	function automatic logic below_level(input logic [MAG_W-1:0] mag);
		logic [63:0] lhs;
		logic [63:0] rhs;
		lhs = {48'd0, mag} * {57'd0, PCT_SCALE} * {39'd0, bright_count};
		rhs = {57'd0, level_pct} * {24'd0, bright_sum};
		return (level_pct != '0) && (bright_count != '0) && (lhs < rhs);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_mag     = '0;
			bright_sum   = '0;
			bright_count = '0;
			level_pct    = THR_RESET;
			bad_beats    = 0;
			expected_voxels.delete();
		end else begin
			if (cfg_we)
				level_pct = cfg_wdata;

			// output beat against the oldest expectation
			if (out_valid && !out_stall) begin
				got.mag_first    = out_mag_first;
				got.mag_second   = out_mag_second;
				got.phase_first  = out_phase_first;
				got.phase_second = out_phase_second;
				got.hide         = masked;
				got.last         = out_last;
				if (expected_voxels.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("%0t: output beat with none expected: %s",
							$time, $sformatf("mag %h/%h phase %0d/%0d masked %b last %b",
							got.mag_first, got.mag_second, got.phase_first,
							got.phase_second, got.hide, got.last));
				end else begin
					want = expected_voxels.pop_front();
					if (got.mag_first !== want.mag_first || got.mag_second !== want.mag_second ||
					    got.phase_first !== want.phase_first ||
					    got.phase_second !== want.phase_second ||
					    got.hide !== want.hide || got.last !== want.last) begin
						bad_beats++;
						if (bad_beats <= 10) begin
							$write("%0t: beat differs: expected %s", $time,
								$sformatf("mag %h/%h phase %0d/%0d masked %b last %b",
								want.mag_first, want.mag_second, want.phase_first,
								want.phase_second, want.hide, want.last));
							$display(", got %s",
								$sformatf("mag %h/%h phase %0d/%0d masked %b last %b",
								got.mag_first, got.mag_second, got.phase_first,
								got.phase_second, got.hide, got.last));
						end
					end
				end
			end

			// input beat: update statistics or predict a mask-pass beat
			if (in_valid && !in_stall) begin
				case (func)
				FUNC_MAX: begin
					if (mag_second > peak_mag)
						peak_mag = mag_second;
				end
				FUNC_AVG: begin
					// bright means strictly above half the peak
					if ({mag_second, 1'b0} > {1'b0, peak_mag}) begin
						sum_next = {1'b0, bright_sum} + {25'd0, mag_second};
						bright_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
						if (bright_count < VOXELS_MAX)
							bright_count = bright_count + CNT_W'(1);
					end
				end
				FUNC_MASK: begin
					hide_it           = below_level(mag_second);
					want.mag_first    = hide_it ? '0 : mag_first;
					want.mag_second   = hide_it ? '0 : mag_second;
					want.phase_first  = hide_it ? '0 : phase_first;
					want.phase_second = hide_it ? '0 : phase_second;
					want.hide         = hide_it;
					want.last         = last;
					expected_voxels.push_back(want);
					// end of the volume clears the statistics, threshold stays
					if (last) begin
						peak_mag     = '0;
						bright_sum   = '0;
						bright_count = '0;
					end
				end
				default: ;
				endcase
			end
		end
		mismatch_count <= bad_beats;
		pending        <= expected_voxels.size();
	end

endmodule

// File: bench/tb_magnitude_threshold_mask.sv
`timescale 1ns / 1ps
// Testbench top for magnitude_threshold_mask: clock, reset, voxel stimulus, output stalls.
// Depends on mtm_pkg, the block itself and mtm_mask_checker.
module tb_magnitude_threshold_mask;
	import mtm_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 250;
	localparam int PHASE_BEATS  = 160;
	localparam int VOL_MAX      = 48;

	typedef struct {
		func_t                     sel;
		logic [MAG_W-1:0]          mag1;
		logic [MAG_W-1:0]          mag2;
		logic signed [PHASE_W-1:0] ph1;
		logic signed [PHASE_W-1:0] ph2;
		logic                      eov;
	} beat_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 func;
	logic [MAG_W-1:0]           mag_first;
	logic [MAG_W-1:0]           mag_second;
	logic signed [PHASE_W-1:0]  phase_first;
	logic signed [PHASE_W-1:0]  phase_second;
	logic                       last;
	logic                       cfg_we;
	logic [THR_W-1:0]           cfg_wdata;
	logic                       out_valid;
	logic                       out_stall;
	logic [MAG_W-1:0]           out_mag_first;
	logic [MAG_W-1:0]           out_mag_second;
	logic signed [PHASE_W-1:0]  out_phase_first;
	logic signed [PHASE_W-1:0]  out_phase_second;
	logic                       masked;
	logic                       out_last;
	int                         mismatch_count;
	int                         pending;

	int    cycles;
	int    voxels_sent;
	bit    burst_mode;
	bit    hold_go;
	logic  hold_off;
	beat_t volume[VOL_MAX];

	magnitude_threshold_mask u_top (.*);

	mtm_mask_checker u_check (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("magnitude_threshold_mask: mismatch");
			$finish;
		end
	end

	// long receiver hold-off so the queue fills and the input stalls
	initial begin
		hold_off = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	// receiver stalls: clean stretches, random stretches, a few solid ones
	initial begin
		int mode;
		int span;
		bit stall_now;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 9);
			span = $urandom_range(4, 48);
			repeat (span) begin
				@(negedge clk);
				if (mode < 4)
					stall_now = 1'b0;
				else if (mode < 9)
					stall_now = ($urandom_range(0, 99) < 35);
				else
					stall_now = 1'b1;
				out_stall <= stall_now | hold_off;
			end
		end
	end

	// sender idle time: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// offer one beat and hold it until accepted
	task automatic send_beat(input beat_t b);
		int gap;
		@(negedge clk);
		in_valid     <= 1'b1;
		func         <= b.sel;
		mag_first    <= b.mag1;
		mag_second   <= b.mag2;
		phase_first  <= b.ph1;
		phase_second <= b.ph2;
		last         <= b.eov;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (b.sel != FUNC_NONE)
			voxels_sent++;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_voxel(input func_t f, input logic [MAG_W-1:0] m1,
			input logic [MAG_W-1:0] m2, input logic signed [PHASE_W-1:0] p1,
			input logic signed [PHASE_W-1:0] p2, input logic eov);
		beat_t b;
		b.sel  = f;
		b.mag1 = m1;
		b.mag2 = m2;
		b.ph1  = p1;
		b.ph2  = p2;
		b.eov  = eov;
		send_beat(b);
	endtask

	// drain the output and let statistics updates finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_level(input logic [THR_W-1:0] pct);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= pct;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one pass over the stored volume, optionally with ignored beats mixed in
	task automatic send_pass(input int n, input func_t f, input bit end_mark, input bit noisy);
		beat_t b;
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 7) == 0) begin
				b.sel  = FUNC_NONE;
				b.mag1 = $urandom;
				b.mag2 = $urandom;
				b.ph1  = $urandom;
				b.ph2  = $urandom;
				b.eov  = $urandom_range(0, 1);
				send_beat(b);
			end
			b     = volume[i];
			b.sel = f;
			if (f == FUNC_MASK)
				b.eov = end_mark && (i == n - 1);
			else
				b.eov = $urandom_range(0, 1);
			send_beat(b);
		end
	endtask

	// build a volume of random voxels and stream it in one of several shapes
	task automatic run_volume(input int n, input int shape);
		int cap;
		int pick;
		case ($urandom_range(0, 3))
		0, 1: cap = 65535;
		2: cap = 4095;
		default: cap = 63;
		endcase
		for (int i = 0; i < n; i++) begin
			volume[i].mag1 = $urandom;
			volume[i].mag2 = $urandom_range(0, cap);
			volume[i].ph1  = $urandom;
			volume[i].ph2  = $urandom;
		end
		if (shape <= 6) begin
			send_pass(n, FUNC_MAX, 1'b1, 1'b0);
			send_pass(n, FUNC_AVG, 1'b1, 1'b0);
			if (burst_mode && n == VOL_MAX)
				hold_go = 1'b1;
			send_pass(n, FUNC_MASK, 1'b1, 1'b0);
		end else if (shape == 7) begin
			// arbitrary selector and end flag on every beat
			for (int i = 0; i < n; i++) begin
				volume[i].sel = func_t'($urandom_range(0, 3));
				volume[i].eov = $urandom_range(0, 1);
				send_beat(volume[i]);
			end
		end else if (shape == 8) begin
			send_pass(n, FUNC_MAX, 1'b1, 1'b1);
			send_pass(n, FUNC_AVG, 1'b1, 1'b1);
			send_pass(n, FUNC_MASK, 1'b1, 1'b1);
		end else begin
			// broken sequence: a pass skipped or the end flag missing
			pick = $urandom_range(0, 2);
			if (pick != 0)
				send_pass(n, FUNC_MAX, 1'b1, 1'b0);
			if (pick != 1)
				send_pass(n, FUNC_AVG, 1'b1, 1'b0);
			send_pass(n, FUNC_MASK, pick != 2, 1'b0);
		end
	endtask

	// stimulus
	initial begin
		logic [THR_W-1:0] levels[6];
		int phase_end;
		int n;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		func         = FUNC_MAX;
		mag_first    = '0;
		mag_second   = '0;
		phase_first  = '0;
		phase_second = '0;
		last         = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = THR_RESET;
		voxels_sent  = 0;
		burst_mode   = 1'b0;
		hold_go      = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty statistics, ignored selector, end flag on early passes
		send_voxel(FUNC_MASK, 16'hFFFF, 16'h0000, -16'sd32768, 16'sd32767, 1'b0);
		send_voxel(FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'sd32767, -16'sd32768, 1'b1);
		send_voxel(FUNC_MAX, 16'h1234, 16'd0, 16'sd0, 16'sd0, 1'b1);
		send_voxel(FUNC_MAX, 16'h0000, 16'hFFFF, -16'sd1, 16'sd1, 1'b0);
		send_voxel(FUNC_MAX, 16'hFFFF, 16'd100, 16'sd5, -16'sd5, 1'b0);
		// just under half the peak is not bright, just over is
		send_voxel(FUNC_AVG, 16'h0001, 16'd32767, 16'sd0, 16'sd0, 1'b0);
		send_voxel(FUNC_AVG, 16'h8000, 16'd32768, 16'sd0, 16'sd0, 1'b1);
		send_voxel(FUNC_AVG, 16'h7FFF, 16'hFFFF, 16'sd0, 16'sd0, 1'b0);
		send_voxel(FUNC_AVG, 16'hAAAA, 16'd0, 16'sd0, 16'sd0, 1'b0);
		send_voxel(FUNC_NONE, 16'h5555, 16'd0, 16'sd0, 16'sd0, 1'b0);
		// threshold at 20 percent: boundary sits between 9830 and 9831
		send_voxel(FUNC_MASK, 16'h0F0F, 16'd9830, 16'sd100, -16'sd100, 1'b0);
		send_voxel(FUNC_MASK, 16'hF0F0, 16'd9831, -16'sd32768, 16'sd32767, 1'b0);
		send_voxel(FUNC_MASK, 16'hFFFF, 16'd0, -16'sd32768, 16'sd32767, 1'b0);
		send_voxel(FUNC_MASK, 16'h0000, 16'hFFFF, 16'sd32767, -16'sd32768, 1'b0);
		send_voxel(FUNC_MASK, 16'h1111, 16'd100, 16'sd1, 16'sd2, 1'b1);
		// statistics cleared by the end of the volume
		send_voxel(FUNC_MASK, 16'h2222, 16'd0, 16'sd3, 16'sd4, 1'b0);
		// average pass with no maximum pass before it
		send_voxel(FUNC_AVG, 16'h3333, 16'd5, 16'sd0, 16'sd0, 1'b0);
		send_voxel(FUNC_MASK, 16'h4444, 16'd0, -16'sd7, 16'sd7, 1'b1);
		// zero threshold disables masking
		write_level(7'd0);
		send_voxel(FUNC_AVG, 16'h5555, 16'd1000, 16'sd0, 16'sd0, 1'b0);
		send_voxel(FUNC_MASK, 16'h6666, 16'd0, 16'sd9, -16'sd9, 1'b1);

		// random volumes over a range of thresholds
		levels[0] = 7'd100;
		levels[1] = 7'd1;
		levels[2] = 7'd127;
		levels[3] = $urandom_range(2, 99);
		levels[4] = $urandom_range(0, 100);
		levels[5] = 7'd20;
		for (int ph = 0; ph < 6; ph++) begin
			write_level(levels[ph]);
			phase_end = voxels_sent + PHASE_BEATS;
			if (ph == 1) begin
				// back-to-back volume that meets the long receiver hold-off
				burst_mode = 1'b1;
				run_volume(VOL_MAX, 0);
			end
			while (voxels_sent < phase_end) begin
				burst_mode = ($urandom_range(0, 4) == 0);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				run_volume(n, $urandom_range(0, 9));
			end
			burst_mode = 1'b0;
		end

		settle();
		repeat (12) @(negedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("magnitude_threshold_mask: match");
		else
			$display("magnitude_threshold_mask: mismatch");
		$finish;
	end

endmodule
